>>> hw/rtl/bmpq_pkg.sv
package bmpq_pkg;

   localparam int DEPTH     = 16;
   localparam int TIME_BITS = 32;
   localparam int TAG_BITS  = 8;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CAP_BITS  = 5;
   localparam int ACT_BITS  = 2;
   localparam int STS_BITS  = 2;
   localparam int OCC_BITS  = 5;

   localparam int REQ_BITS  = ACT_BITS + TIME_BITS + TAG_BITS;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS  = STS_BITS + TIME_BITS + TAG_BITS + OCC_BITS;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   localparam logic [ACT_BITS-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_DEQUEUE = 2'd1;

   localparam logic [STS_BITS-1:0] STS_OK    = 2'd0;
   localparam logic [STS_BITS-1:0] STS_FULL  = 2'd1;
   localparam logic [STS_BITS-1:0] STS_EMPTY = 2'd2;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [TIME_BITS-1:0] key;
      logic [TAG_BITS-1:0]  tag;
   } cell_ctl_type;

endpackage

>>> hw/rtl/bounded_min_priority_queue_unit.sv
// Bounded min-priority queue of timed events, kept sorted in a row of cells.
// Request beats (req_*) carry an action: enqueue an event, dequeue the front
// or peek at it. Each request beat yields exactly one response beat (rsp_*)
// with a status, the front event after the action and the occupancy.
// Enqueue on a queue at its limit returns full; dequeue or peek on an empty
// queue returns empty; in both cases nothing changes. Action code three acts
// as a peek. csr_wr_en/csr_wr_data set the capacity limit (reset 16, values
// above the depth behave as the depth, zero rejects every enqueue).
// The response beat is registered and valid in the cycle after the request
// beat is accepted. Throughput: one beat per cycle while responses are taken;
// every cell compares its key with the broadcast key and loads itself, its
// left or right neighbour or the new event in the same cycle, so an action
// finishes in the cycle it is accepted. Reset empties the queue and restores
// the limit; cell contents are not cleared, only the held count marks which
// cells are live. When the receiver stalls, the response register holds its
// beat and req_tready drops until that beat is taken.
module bounded_min_priority_queue_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] action, [33:2] event_time, [41:34] event_tag, rest zero
   input  logic [8*bmpq_pkg::REQ_BYTES-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] status, [33:2] front_time, [41:34] front_tag, [46:42] occupancy
   output logic [8*bmpq_pkg::RSP_BYTES-1:0]      rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [bmpq_pkg::CAP_BITS-1:0]         csr_wr_data
);

   localparam int D  = bmpq_pkg::DEPTH;
   localparam int TB = bmpq_pkg::TIME_BITS;
   localparam int GB = bmpq_pkg::TAG_BITS;
   localparam int CB = bmpq_pkg::CNT_BITS;

   // request fields
   logic [bmpq_pkg::ACT_BITS-1:0] req_action;
   logic [TB-1:0]                 req_key;
   logic [GB-1:0]                 req_tag;

   assign req_action = req_tdata[bmpq_pkg::ACT_BITS-1:0];
   assign req_key    = req_tdata[bmpq_pkg::ACT_BITS +: TB];
   assign req_tag    = req_tdata[bmpq_pkg::ACT_BITS + TB +: GB];

   // control state
   logic [CB-1:0]                 count_ff, count_in;
   logic [bmpq_pkg::CAP_BITS-1:0] cap_ff;
   logic                          rsp_valid_ff;
   logic [8*bmpq_pkg::RSP_BYTES-1:0] rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          is_full;
   logic                          is_empty;
   logic [bmpq_pkg::STS_BITS-1:0] status;
   bmpq_pkg::cell_ctl_type        ctl;

   // cell row
   logic [D-1:0]  occ;
   logic [D-1:0]  shift;
   logic [TB-1:0] key_q   [D];
   logic [GB-1:0] tag_q   [D];
   logic [TB-1:0] nxt_key [D];
   logic [GB-1:0] nxt_tag [D];

   logic [TB-1:0] front_key;
   logic [GB-1:0] front_tag;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // full when at the limit or at the physical depth
   assign is_full  = (count_ff >= CB'(cap_ff)) || (count_ff >= CB'(D));
   assign is_empty = (count_ff == '0);

   always_comb begin
      ctl.key  = req_key;
      ctl.tag  = req_tag;
      ctl.op   = bmpq_pkg::CELL_HOLD;
      status   = bmpq_pkg::STS_OK;
      count_in = count_ff;
      case (req_action)
         bmpq_pkg::ACT_ENQUEUE: begin
            if (is_full) begin
               status = bmpq_pkg::STS_FULL;
            end else begin
               ctl.op   = req_fire ? bmpq_pkg::CELL_INSERT : bmpq_pkg::CELL_HOLD;
               count_in = req_fire ? count_ff + CB'(1) : count_ff;
            end
         end
         bmpq_pkg::ACT_DEQUEUE: begin
            if (is_empty) begin
               status = bmpq_pkg::STS_EMPTY;
            end else begin
               ctl.op   = req_fire ? bmpq_pkg::CELL_REMOVE : bmpq_pkg::CELL_HOLD;
               count_in = req_fire ? count_ff - CB'(1) : count_ff;
            end
         end
         default: begin
            // peek, and the spare code behaves as a peek
            if (is_empty) begin
               status = bmpq_pkg::STS_EMPTY;
            end
         end
      endcase
   end

   // the row: each cell sees its left neighbour for inserts and its right
   // neighbour for removals; the last cell just holds on a removal
   genvar gi;
   generate
      for (gi = 0; gi < D; gi++) begin : g_cell
         logic          p_shift;
         logic [TB-1:0] p_key, n_key;
         logic [GB-1:0] p_tag, n_tag;

         assign occ[gi] = (CB'(gi) < count_ff);

         if (gi == 0) begin : g_first
            assign p_shift = 1'b0;
            assign p_key   = ctl.key;
            assign p_tag   = ctl.tag;
         end else begin : g_mid
            assign p_shift = shift[gi-1];
            assign p_key   = key_q[gi-1];
            assign p_tag   = tag_q[gi-1];
         end

         if (gi == D - 1) begin : g_last
            assign n_key = key_q[gi];
            assign n_tag = tag_q[gi];
         end else begin : g_inner
            assign n_key = key_q[gi+1];
            assign n_tag = tag_q[gi+1];
         end

         bmpq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (occ[gi]),
            .prev_shift (p_shift),
            .prev_key   (p_key),
            .prev_tag   (p_tag),
            .next_key   (n_key),
            .next_tag   (n_tag),
            .shift      (shift[gi]),
            .key_q      (key_q[gi]),
            .tag_q      (tag_q[gi]),
            .nxt_key    (nxt_key[gi]),
            .nxt_tag    (nxt_tag[gi])
         );
      end
   endgenerate

   // front after the action: zero when the queue ends up empty
   assign front_key = (count_in == '0) ? '0 : nxt_key[0];
   assign front_tag = (count_in == '0) ? '0 : nxt_tag[0];

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[bmpq_pkg::STS_BITS-1:0]                 = status;
      rsp_data_in[bmpq_pkg::STS_BITS +: TB]               = front_key;
      rsp_data_in[bmpq_pkg::STS_BITS + TB +: GB]          = front_tag;
      rsp_data_in[bmpq_pkg::STS_BITS + TB + GB +: bmpq_pkg::OCC_BITS] =
         bmpq_pkg::OCC_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= bmpq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: load on every accepted beat, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the held count never passes the number of cells
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(D))
      else $error("held count beyond depth");

   // a waiting response reports the occupancy now held
   a_rsp_occ : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         rsp_data_ff[bmpq_pkg::STS_BITS + TB + GB +: bmpq_pkg::OCC_BITS]
            == bmpq_pkg::OCC_BITS'(count_ff))
      else $error("response occupancy disagrees with held count");

   // an accepted enqueue that is not full grows the queue by one
   a_enq_grows : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == bmpq_pkg::ACT_ENQUEUE && !is_full) |=>
         count_ff == $past(count_ff) + CB'(1))
      else $error("enqueue did not grow the queue");

   // the two front cells stay in key order
   a_front_sorted : assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CB'(2)) |-> (key_q[0] <= key_q[1]))
      else $error("front cells out of order");

endmodule

>>> hw/rtl/bmpq_cell.sv
module bmpq_cell (
   input  logic                           clock,
   input  bmpq_pkg::cell_ctl_type         ctl,
   input  logic                           occupied,
   input  logic                           prev_shift,
   input  logic [bmpq_pkg::TIME_BITS-1:0] prev_key,
   input  logic [bmpq_pkg::TAG_BITS-1:0]  prev_tag,
   input  logic [bmpq_pkg::TIME_BITS-1:0] next_key,
   input  logic [bmpq_pkg::TAG_BITS-1:0]  next_tag,
   output logic                           shift,
   output logic [bmpq_pkg::TIME_BITS-1:0] key_q,
   output logic [bmpq_pkg::TAG_BITS-1:0]  tag_q,
   output logic [bmpq_pkg::TIME_BITS-1:0] nxt_key,
   output logic [bmpq_pkg::TAG_BITS-1:0]  nxt_tag
);

   logic [bmpq_pkg::TIME_BITS-1:0] key_ff, key_in;
   logic [bmpq_pkg::TAG_BITS-1:0]  tag_ff, tag_in;
   logic                           own_later;

   // strictly later keys move back; equal keys stay ahead of the new event
   assign own_later = !occupied || (key_ff > ctl.key);
   assign shift     = occupied && (key_ff > ctl.key);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      case (ctl.op)
         bmpq_pkg::CELL_INSERT: begin
            if (prev_shift) begin
               key_in = prev_key;
               tag_in = prev_tag;
            end else if (own_later) begin
               key_in = ctl.key;
               tag_in = ctl.tag;
            end
         end
         bmpq_pkg::CELL_REMOVE: begin
            key_in = next_key;
            tag_in = next_tag;
         end
         default: begin
            key_in = key_ff;
            tag_in = tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key_q   = key_ff;
   assign tag_q   = tag_ff;
   assign nxt_key = key_in;
   assign nxt_tag = tag_in;

endmodule
